// File: hdl/dsdpcm_pkg.sv
// Package with the shared types and filter coefficient tables of the DSD to PCM decimator.
`timescale 1ns / 1ps
`default_nettype none
package dsdpcm_pkg;

  localparam int TAPS = 64;
  localparam int TAP_W = $clog2(TAPS);
  localparam int PHASES = 4;
  localparam int ACC_W = 36;
  localparam int PAIR_W = 34;

  typedef logic [TAP_W-1:0] tap_idx_t;

  typedef struct packed {
    logic     load;
    logic     issue;
    tap_idx_t tap;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  localparam logic [31:0] COEF_A [TAPS] = '{
    32'hFFFFFD8D, 32'h000022FA, 32'h0000EEA9, 32'h00039FBB,
    32'h000A3E4C, 32'h0016F0C1, 32'h002A240B, 32'h003FC2FC,
    32'h004CD303, 32'h003FD88F, 32'h00066DA6, 32'hFF989DE7,
    32'hFF06E0F9, 32'hFE83582C, 32'hFE5CF09A, 32'hFEE5F675,
    32'h00487499, 32'h02570595, 32'h0472B4D2, 32'h059F2993,
    32'h04D11818, 32'h0169A612, 32'hFBB5501B, 32'hF533E1B7,
    32'hF0758AEC, 32'hF07A9686, 32'hF7B657E0, 32'h07063043,
    32'h1D03C535, 32'h3606AD25, 32'h4CEFFBCC, 32'h5C8DA13E,
    32'h6123BEC1, 32'h599357D1, 32'h47B44AE7, 32'h2FC1B9B5,
    32'h170EA7B6, 32'h027952FF, 32'hF52515AD, 32'hEFDFA6D9,
    32'hF150902E, 32'hF6C72731, 32'hFD49FCCD, 32'h0282B679,
    32'h053FEC8B, 32'h0579E5F9, 32'h03F74B38, 32'h01C9FCFB,
    32'hFFDC0F81, 32'hFEAFCD15, 32'hFE5900D2, 32'hFE9EE905,
    32'hFF2C893E, 32'hFFB89EA7, 32'h0019B211, 32'h00469C7E,
    32'h004B3C9A, 32'h003A99CC, 32'h0024D978, 32'h00131E86,
    32'h00081780, 32'h0002AC4F, 32'h00009E5E, 32'h00001230
  };

  localparam logic [31:0] COEF_B [TAPS] = '{
    32'h00000314, 32'h00003D67, 32'h00015C2B, 32'h0004D1A2,
    32'h000CC84D, 32'h001B30B4, 32'h002F9E6A, 32'h00446C46,
    32'h004CCAF7, 32'h00364117, 32'hFFEFC3B0, 32'hFF7631DE,
    32'hFEE1F45B, 32'hFE6D91DA, 32'hFE6C08A8, 32'hFF2A2811,
    32'h00C030C4, 32'h02E55F14, 32'h04DF45A2, 32'h05A43E50,
    32'h04377E46, 32'h002A34D4, 32'hFA126763, 32'hF3BC30FA,
    32'hEFE76969, 32'hF18AFC73, 32'hFACBCE96, 32'h0C00DF2B,
    32'h232B26C0, 32'h3C2A25CF, 32'h51B50D57, 32'h5ED40A6A,
    32'h605D787C, 32'h55F107F6, 32'h4215F8B4, 32'h29715CC3,
    32'h115DADC4, 32'hFE639583, 32'hF3178B7C, 32'hEFB1D5DF,
    32'hF26C4484, 32'hF86A51E2, 32'hFEC883AD, 32'h03728A0F,
    32'h058584BA, 32'h05387E5B, 32'h03717157, 32'h01417633,
    32'hFF7C5625, 32'hFE875D03, 32'hFE5EFDE7, 32'hFEBEE31E,
    32'hFF51EDAE, 32'hFFD5C4EB, 32'h00299950, 32'h004AD397,
    32'h004856AD, 32'h00352853, 32'h001FD7A2, 32'h000FBC38,
    32'h00064BAE, 32'h0001EE0C, 32'h0000650F, 32'h0000083B
  };

endpackage
`default_nettype wire

// File: hdl/dsdpcm_if.sv
// Valid/ready stream interfaces for the DSD input and the PCM output.
`timescale 1ns / 1ps
`default_nettype none
interface dsdpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] dsd_byte;
  modport source (output valid, output dsd_byte, input ready);
  modport sink (input valid, input dsd_byte, output ready);
endinterface

interface dsdpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pcm_value;
  modport source (output valid, output pcm_value, input ready);
  modport sink (input valid, input pcm_value, output ready);
endinterface
`default_nettype wire

// File: hdl/dsdpcm_ctrl.sv
// Controller state machine that sequences loading, tap accumulation and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module dsdpcm_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire dsdpcm_pkg::dp_status_t status,
  output dsdpcm_pkg::dp_cmd_t         cmd
);
  import dsdpcm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam tap_idx_t LAST_TAP = tap_idx_t'(TAPS - 1);

  logic [1:0] state;
  logic [1:0] state_next;
  tap_idx_t   tap_cnt;
  tap_idx_t   tap_cnt_next;

  always_comb begin
    state_next   = state;
    tap_cnt_next = tap_cnt;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.tap      = tap_cnt;
    case (state)
      ST_IDLE: begin
        // No beat is taken while reset is held.
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load     = 1'b1;
          tap_cnt_next = '0;
          state_next   = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue    = 1'b1;
        tap_cnt_next = tap_cnt + tap_idx_t'(1);
        if (tap_cnt == LAST_TAP) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // Hold the finished total until the output register can take it.
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tap_cnt <= '0;
    end else begin
      state   <= state_next;
      tap_cnt <= tap_cnt_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dsdpcm_datapath.sv
// Datapath with phase histories, coefficient lookup, accumulator, rounding and output register.
`timescale 1ns / 1ps
`default_nettype none
module dsdpcm_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           dsd_byte,
  input  wire dsdpcm_pkg::dp_cmd_t  cmd,
  output dsdpcm_pkg::dp_status_t    status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        pcm_value
);
  import dsdpcm_pkg::*;

  // Each history holds the oldest slot in bit 0 and the newest in the top bit.
  logic [TAPS-1:0]          hist [PHASES];
  logic signed [PAIR_W-1:0] pair0;
  logic signed [PAIR_W-1:0] pair1;
  logic                     s1_valid;
  logic [ACC_W-1:0]         acc;
  logic                     started;

  logic signed [PAIR_W-1:0] term [PHASES];
  logic [31:0]              coef [PHASES];
  tap_idx_t                 tap_rev;
  logic [32:0]              s33;
  logic [4:0]               top_bits;
  logic                     emit;
  logic [33:0]              rsum;
  logic [32:0]              r33;
  logic [31:0]              sat;

  assign tap_rev = ~cmd.tap;
  assign coef[0] = COEF_A[cmd.tap];
  assign coef[1] = COEF_B[cmd.tap];
  assign coef[2] = COEF_B[tap_rev];
  assign coef[3] = COEF_A[tap_rev];

  always_comb begin
    for (int p = 0; p < PHASES; p++) begin
      if (hist[p][0]) begin
        term[p] = PAIR_W'(signed'(coef[p]));
      end else begin
        term[p] = -PAIR_W'(signed'(coef[p]));
      end
    end
  end

  assign s33      = acc[ACC_W-1:3];
  assign top_bits = s33[32:28];
  assign emit     = started | (&top_bits) | ~(|top_bits);
  // Round half up: floor((t + 1) / 2) on the sign-extended value.
  assign rsum     = {s33[32], s33} + 34'd1;
  assign r33      = rsum[33:1];

  always_comb begin
    if (r33[32] != r33[31]) begin
      sat = r33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat = r33[31:0];
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < PHASES; p++) begin
        hist[p] <= '0;
      end
    end else if (cmd.load) begin
      for (int p = 0; p < PHASES; p++) begin
        hist[p] <= {dsd_byte[3-p], dsd_byte[7-p], hist[p][TAPS-1:2]};
      end
    end else if (cmd.issue) begin
      for (int p = 0; p < PHASES; p++) begin
        hist[p] <= {hist[p][0], hist[p][TAPS-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    pair0 <= term[0] + term[1];
    pair1 <= term[2] + term[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      acc      <= '0;
    end else begin
      s1_valid <= cmd.issue;
      if (cmd.load) begin
        acc <= '0;
      end else if (s1_valid) begin
        acc <= acc + ACC_W'(pair0) + ACC_W'(pair1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        started <= emit;
      end
      if (cmd.finish && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && emit) begin
      pcm_value <= sat;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dsd_to_pcm_decimator_top.sv
// Top level of the DSD to PCM polyphase decimator.
//
//   channel   direction  payload                 beat
//   dsd_in    in         dsd_byte   [7:0]        one DSD byte, bit 7 oldest
//   pcm_out   out        pcm_value  [31:0] s     one PCM sample, or none
//
// After acceptance a byte passes through one load step, the shared four-phase tap loop
// over all 64 taps, one drain step and one finish step before its sample is ready.
// The next byte is accepted after the finish step, which fills the output register if a sample is emitted.
// Synchronous reset clears the phase histories, the accumulator, the started flag and out_valid.
// A stalled output holds the finish step, and with it the next acceptance.
`timescale 1ns / 1ps
`default_nettype none
module dsd_to_pcm_decimator_top (
  input  wire logic clk,
  input  wire logic rst,
  dsdpcm_in_if.sink     dsd_in,
  dsdpcm_out_if.source  pcm_out
);
  import dsdpcm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dsdpcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dsd_in.valid),
    .in_ready (dsd_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dsdpcm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .dsd_byte   (dsd_in.dsd_byte),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (pcm_out.valid),
    .out_ready  (pcm_out.ready),
    .pcm_value  (pcm_out.pcm_value)
  );

endmodule
`default_nettype wire
